FILE: rtl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Phase encoding, opcodes, event codes and header constants shared by the
// receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_KEY     = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	localparam logic [3:0] OP_TEXT  = 4'd1;
	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;

	localparam logic [1:0] EV_TEXT  = 2'd0;
	localparam logic [1:0] EV_PING  = 2'd1;
	localparam logic [1:0] EV_EPING = 2'd2;
	localparam logic [1:0] EV_CLOSE = 2'd3;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Value of the header byte counter on the final byte of each part.
	localparam logic [2:0] CNT_EXT16_END = 3'd1;
	localparam logic [2:0] CNT_EXT64_END = 3'd7;
	localparam logic [2:0] CNT_KEY_END   = 3'd3;

	localparam int LEN_W = 64;
	localparam int KEY_W = 32;

endpackage

FILE: rtl/websocket_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Byte-serial frame parser: decodes the header, extended length and masking
// key, unmasks the payload and reports text bytes, ping bytes, empty pings
// and the close event.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata            tuser           tlast
// s_axis   in         rx_byte [7:0]    -               -
// m_axis   out        data_byte [7:0]  event_res [1:0] last
//
// One byte is accepted every cycle while m_axis does not stall; its result
// passes through the input register, then the result register, to m_axis.
// The rate is set by the single parse step between the two registers.
// arst_n clears the parser to await a new frame header and leaves no
// transaction pending. A stall on m_axis holds the result register and backs
// up into the input register before s_axis_tready drops.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic [1:0] m_axis_tuser,   // [1:0] event_res
	output logic       m_axis_tlast
);
	import wsfr_pkg::*;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 out_valid_q;
	logic [7:0]           out_data_q;
	logic [1:0]           out_event_q;
	logic                 out_last_q;

	phase_t               phase_q, phase_d;
	logic [3:0]           opcode_q, opcode_d;
	logic                 mask_q, mask_d;
	logic [LEN_W-1:0]     rem_q, rem_d;
	logic [2:0]           cnt_q, cnt_d;
	logic [KEY_W-1:0]     key_q, key_d;
	logic [1:0]           pidx_q, pidx_d;
	logic                 halted_q, halted_d;

	logic                 advance;
	logic                 step;
	logic                 hdr_empty;
	logic                 pay_last;
	logic [7:0]           key_byte;
	logic [7:0]           unmasked;
	logic [LEN_W-1:0]     rem_shift;

	logic                 res_valid;
	logic [1:0]           res_event;
	logic [7:0]           res_data;
	logic                 res_last;

	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance && !halted_q;
	assign s_axis_tready = !valid_s1 || advance;

	assign pay_last  = (rem_q == LEN_W'(1));
	assign rem_shift = {rem_q[LEN_W-9:0], byte_s1};

	always_comb begin
		case (pidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign unmasked = mask_q ? (byte_s1 ^ key_byte) : byte_s1;

	// Next state of the parser
	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		mask_d    = mask_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		key_d     = key_q;
		pidx_d    = pidx_q;
		halted_d  = halted_q;
		hdr_empty = 1'b0;
		if (step) begin
			case (phase_q)
				PH_HDR0: begin
					opcode_d = byte_s1[3:0];
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					mask_d = byte_s1[7];
					cnt_d  = 3'd0;
					rem_d  = '0;
					if (byte_s1[6:0] == LEN_EXT16) begin
						phase_d = PH_EXT16;
					end else if (byte_s1[6:0] == LEN_EXT64) begin
						phase_d = PH_EXT64;
					end else begin
						rem_d = LEN_W'(byte_s1[6:0]);
						if (byte_s1[7]) begin
							key_d   = '0;
							phase_d = PH_KEY;
						end else begin
							pidx_d = 2'd0;
							if (byte_s1[6:0] != 7'd0) begin
								phase_d = PH_PAYLOAD;
							end else begin
								phase_d   = PH_HDR0;
								hdr_empty = 1'b1;
							end
						end
					end
				end
				PH_EXT16, PH_EXT64: begin
					rem_d = rem_shift;
					cnt_d = cnt_q + 3'd1;
					if ((phase_q == PH_EXT16 && cnt_q == CNT_EXT16_END) ||
					    (phase_q == PH_EXT64 && cnt_q == CNT_EXT64_END)) begin
						cnt_d = 3'd0;
						if (mask_q) begin
							key_d   = '0;
							phase_d = PH_KEY;
						end else begin
							pidx_d = 2'd0;
							if (rem_shift != '0) begin
								phase_d = PH_PAYLOAD;
							end else begin
								phase_d   = PH_HDR0;
								hdr_empty = 1'b1;
							end
						end
					end
				end
				PH_KEY: begin
					key_d = {key_q[KEY_W-9:0], byte_s1};
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == CNT_KEY_END) begin
						cnt_d  = 3'd0;
						pidx_d = 2'd0;
						if (rem_q != '0) begin
							phase_d = PH_PAYLOAD;
						end else begin
							phase_d   = PH_HDR0;
							hdr_empty = 1'b1;
						end
					end
				end
				PH_PAYLOAD: begin
					pidx_d = pidx_q + 2'd1;
					rem_d  = rem_q - LEN_W'(1);
					if (pay_last) begin
						phase_d = PH_HDR0;
					end
					if (pay_last && opcode_q == OP_CLOSE) begin
						halted_d = 1'b1;
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
			if (hdr_empty && opcode_q == OP_CLOSE) begin
				halted_d = 1'b1;
			end
		end
	end

	// Result produced by the byte in the input register
	always_comb begin
		res_valid = 1'b0;
		res_event = EV_TEXT;
		res_data  = 8'd0;
		res_last  = 1'b1;
		if (step) begin
			if (phase_q == PH_PAYLOAD) begin
				res_last = pay_last;
				if (opcode_q == OP_TEXT) begin
					res_valid = 1'b1;
					res_event = EV_TEXT;
					res_data  = unmasked;
				end else if (opcode_q == OP_PING) begin
					res_valid = 1'b1;
					res_event = EV_PING;
					res_data  = unmasked;
				end else if (opcode_q == OP_CLOSE && pay_last) begin
					res_valid = 1'b1;
					res_event = EV_CLOSE;
				end
			end else if (hdr_empty) begin
				if (opcode_q == OP_CLOSE) begin
					res_valid = 1'b1;
					res_event = EV_CLOSE;
				end else if (opcode_q == OP_PING) begin
					res_valid = 1'b1;
					res_event = EV_EPING;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			rem_q    <= '0;
			cnt_q    <= 3'd0;
			key_q    <= '0;
			pidx_q   <= 2'd0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			rem_q    <= rem_d;
			cnt_q    <= cnt_d;
			key_q    <= key_d;
			pidx_q   <= pidx_d;
			halted_q <= halted_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q  <= res_data;
			out_event_q <= res_event;
			out_last_q  <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_event_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: sim/ws_frame_checker.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver checker
// Watches both stream channels of the receiver, parses every accepted byte
// with its own copy of the frame parser state, queues the results that byte
// should cause and compares each result transaction against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ws_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [7:0] data_byte
	input  logic [1:0] m_axis_tuser,   // [1:0] event_res
	input  logic       m_axis_tlast,
	output int         errors,
	output int         pending
);
	import wsfr_pkg::*;

	typedef struct packed {
		logic [1:0] ev;
		logic [7:0] data;
		logic       last;
	} ws_result_t;

	ws_result_t due_results[$];

	// Parser state as the receiver should hold it.
	phase_t      phase_q;
	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [63:0] remaining_q;
	logic [2:0]  hdr_count_q;
	logic [31:0] key_q;
	logic [1:0]  pay_index_q;
	logic        halted_q;

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("ws_frame_checker: %s", msg);
		errors++;
	endtask

	function automatic void queue_result(input logic [1:0] ev, input logic [7:0] data,
			input logic last);
		ws_result_t r;
		r.ev   = ev;
		r.data = data;
		r.last = last;
		due_results.insert(due_results.size(), r);
	endfunction

	function automatic void clear_parser();
		phase_q     = PH_HDR0;
		opcode_q    = '0;
		masked_q    = 1'b0;
		remaining_q = '0;
		hdr_count_q = '0;
		key_q       = '0;
		pay_index_q = '0;
		halted_q    = 1'b0;
	endfunction

	// Header fully taken: an empty frame reports at once, otherwise the payload follows.
	function automatic void end_of_header();
		pay_index_q = '0;
		if (remaining_q != 64'd0) begin
			phase_q = PH_PAYLOAD;
		end else begin
			phase_q = PH_HDR0;
			if (opcode_q == OP_CLOSE) begin
				halted_q = 1'b1;
				queue_result(EV_CLOSE, 8'h00, 1'b1);
			end else if (opcode_q == OP_PING) begin
				queue_result(EV_EPING, 8'h00, 1'b1);
			end
		end
	endfunction

	function automatic void end_of_length();
		hdr_count_q = '0;
		if (masked_q) begin
			key_q   = '0;
			phase_q = PH_KEY;
		end else begin
			end_of_header();
		end
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b);
		logic [7:0] data;
		logic       last;
		logic [2:0] final_count;
		if (halted_q)
			return;
		case (phase_q)
			PH_HDR0: begin
				opcode_q = b[3:0];
				phase_q  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_q    = b[7];
				hdr_count_q = '0;
				remaining_q = '0;
				if (b[6:0] == LEN_EXT16) begin
					phase_q = PH_EXT16;
				end else if (b[6:0] == LEN_EXT64) begin
					phase_q = PH_EXT64;
				end else begin
					remaining_q = {57'd0, b[6:0]};
					end_of_length();
				end
			end
			PH_EXT16, PH_EXT64: begin
				final_count = (phase_q == PH_EXT16) ? CNT_EXT16_END : CNT_EXT64_END;
				remaining_q = {remaining_q[55:0], b};
				if (hdr_count_q == final_count)
					end_of_length();
				else
					hdr_count_q = hdr_count_q + 3'd1;
			end
			PH_KEY: begin
				key_q = {key_q[23:0], b};
				if (hdr_count_q == CNT_KEY_END) begin
					hdr_count_q = '0;
					end_of_header();
				end else begin
					hdr_count_q = hdr_count_q + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				// The first key byte received sits in the top bits of the key.
				data = masked_q ? (b ^ key_q[24 - 8 * pay_index_q +: 8]) : b;
				pay_index_q = pay_index_q + 2'd1;
				remaining_q = remaining_q - 64'd1;
				last = (remaining_q == 64'd0);
				if (last)
					phase_q = PH_HDR0;
				if (opcode_q == OP_TEXT) begin
					queue_result(EV_TEXT, data, last);
				end else if (opcode_q == OP_PING) begin
					queue_result(EV_PING, data, last);
				end else if (opcode_q == OP_CLOSE && last) begin
					halted_q = 1'b1;
					queue_result(EV_CLOSE, 8'h00, 1'b1);
				end
			end
			default: begin
				phase_q = PH_HDR0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ws_result_t want;
		if (!arst_n) begin
			clear_parser();
			due_results.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				parse_rx_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result event=%0d data=%02h last=%0b",
						m_axis_tuser, m_axis_tdata, m_axis_tlast));
				end else begin
					want = due_results.pop_front();
					if (m_axis_tuser !== want.ev)
						flag_mismatch($sformatf("event %0d, expected %0d",
							m_axis_tuser, want.ev));
					if (m_axis_tdata !== want.data)
						flag_mismatch($sformatf("data %02h, expected %02h",
							m_axis_tdata, want.data));
					if (m_axis_tlast !== want.last)
						flag_mismatch($sformatf("last %0b, expected %0b",
							m_axis_tlast, want.last));
				end
			end
		end
		pending = due_results.size();
	end

endmodule

FILE: sim/websocket_frame_receiver_unit_tb.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver testbench
// Feeds the receiver a byte stream of whole frames of every kind, with short,
// 16-bit and 64-bit lengths, masked and unmasked, under random gaps on both
// channels, and ends with a close frame followed by bytes that must be
// discarded. The checker beside the receiver predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_receiver_unit_tb;
	import wsfr_pkg::*;

	typedef enum int {
		FORM_SHORT,
		FORM_EXT16,
		FORM_EXT64
	} len_form_t;

	localparam logic [3:0] OP_CONT   = 4'd0;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_PONG   = 4'd10;

	localparam int unsigned BYTE_TARGET = 1300;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned QUIET_GAP   = 20;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	int          errors;
	int          pending;
	int unsigned sent_bytes  = 0;
	int unsigned cycle_count = 0;
	logic        calm;

	// A stretch of the run with no gaps on either channel.
	assign calm = (sent_bytes >= 500) && (sent_bytes < 800);

	always #5 clk = ~clk;

	websocket_frame_receiver_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	ws_frame_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 11);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Called just after a rising edge; returns just after the accepting edge.
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_bytes++;
	endtask

	task automatic send_frame(input logic [3:0] opcode, input logic masked,
			input logic [63:0] len, input len_form_t form);
		logic [31:0] key;
		key = $urandom();
		// The fin and reserved bits are random: the receiver ignores them.
		send_byte({4'($urandom_range(15)), opcode});
		case (form)
			FORM_EXT16: begin
				send_byte({masked, LEN_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			FORM_EXT64: begin
				send_byte({masked, LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8 * i +: 8]);
			end
			default: begin
				send_byte({masked, len[6:0]});
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		for (longint unsigned k = 0; k < len; k++)
			send_byte(8'($urandom_range(255)));
	endtask

	// Holds the sender off until every expected result has come out.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic send_random_frame();
		logic [3:0]  opcode;
		logic [63:0] len;
		len_form_t   form;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			opcode = OP_TEXT;
		else if (pick < 65)
			opcode = OP_PING;
		else begin
			opcode = 4'($urandom_range(15));
			if (opcode == OP_CLOSE)
				opcode = OP_PONG;
		end
		pick = $urandom_range(99);
		if (pick < 70) begin
			form = FORM_SHORT;
			len  = ($urandom_range(19) == 0) ? 64'd125 : 64'($urandom_range(12));
		end else if (pick < 85) begin
			form = FORM_EXT16;
			len  = ($urandom_range(9) == 0) ? 64'($urandom_range(300, 250))
				: 64'($urandom_range(40));
		end else begin
			form = FORM_EXT64;
			len  = 64'($urandom_range(40));
		end
		send_frame(opcode, 1'($urandom_range(1)), len, form);
	endtask

	initial begin
		bit drained_mid;
		drained_mid = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: text, ping, binary and continuation frames, and each length form.
		send_frame(OP_TEXT, 1'b0, 64'd1, FORM_SHORT);
		send_frame(OP_TEXT, 1'b1, 64'd5, FORM_EXT16);
		send_frame(OP_PING, 1'b0, 64'd2, FORM_SHORT);
		send_frame(OP_PING, 1'b1, 64'd0, FORM_SHORT);
		send_frame(OP_TEXT, 1'b0, 64'd0, FORM_SHORT);
		send_frame(OP_BINARY, 1'b1, 64'd1, FORM_SHORT);
		send_frame(OP_CONT, 1'b0, 64'd0, FORM_EXT64);
		drain_results();

		while (sent_bytes < BYTE_TARGET) begin
			send_random_frame();
			if (!drained_mid && sent_bytes >= 900) begin
				drained_mid = 1'b1;
				drain_results();
			end
		end

		// The close frame stops the parser; what follows must be discarded.
		if ($urandom_range(1))
			send_frame(OP_CLOSE, 1'($urandom_range(1)), 64'd0, FORM_SHORT);
		else
			send_frame(OP_CLOSE, 1'($urandom_range(1)), 64'd3, FORM_SHORT);
		send_frame(OP_TEXT, 1'b0, 64'd4, FORM_SHORT);
		send_frame(OP_PING, 1'b1, 64'd0, FORM_SHORT);
		drain_results();
		repeat (QUIET_GAP) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
